>>> src/ple_pkg.sv
`default_nettype none

package ple_pkg;

   // Store geometry.
   localparam int CAPACITY   = 64;
   localparam int DATA_WIDTH = 32;
   localparam int ADDR_W     = $clog2(CAPACITY);
   localparam int CNT_W      = $clog2(CAPACITY + 1);
   localparam int POS_W      = 7;
   localparam int OP_W       = 2;
   localparam int STATUS_W   = 2;

   // Operation codes.
   localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
   localparam logic [OP_W-1:0] OP_DELETE = 2'd1;
   localparam logic [OP_W-1:0] OP_UPDATE = 2'd2;
   localparam logic [OP_W-1:0] OP_SEARCH = 2'd3;

   // Result status codes.
   localparam logic [STATUS_W-1:0] ST_DONE   = 2'd0;
   localparam logic [STATUS_W-1:0] ST_BADPOS = 2'd1;
   localparam logic [STATUS_W-1:0] ST_FULL   = 2'd2;

   // Controller to datapath.
   typedef struct packed {
      logic load_req;
      logic latch_status;
      logic idx_init;
      logic idx_step;
      logic mem_rd;
      logic shift_wr;
      logic put_wr;
      logic count_inc;
      logic count_dec;
      logic set_found;
      logic load_rsp;
   } cmd_type;

   // Datapath to controller.
   typedef struct packed {
      logic [OP_W-1:0] op;
      logic            reject;
      logic            more;
      logic            match;
   } stat_type;

endpackage

`default_nettype wire

>>> src/ple_datapath.sv
`default_nettype none

module ple_datapath (
   input  wire                           clock,
   input  wire                           reset,
   input  wire  [ple_pkg::OP_W-1:0]      req_opcode,
   input  wire  [ple_pkg::POS_W-1:0]     req_position,
   input  wire  [ple_pkg::DATA_WIDTH-1:0] req_value,
   input  wire  ple_pkg::cmd_type        cmd,
   output ple_pkg::stat_type             stat,
   output logic [ple_pkg::STATUS_W-1:0]  rsp_status,
   output logic                          rsp_found,
   output logic [ple_pkg::POS_W-1:0]     rsp_match_index,
   output logic [ple_pkg::POS_W-1:0]     rsp_length
);
   import ple_pkg::*;

   logic [DATA_WIDTH-1:0] mem [CAPACITY];

   logic [OP_W-1:0]       op_ff;
   logic [POS_W-1:0]      pos_ff;
   logic [DATA_WIDTH-1:0] word_ff;
   logic [CNT_W-1:0]      count_ff, count_in;
   logic [CNT_W-1:0]      idx_ff, idx_in;
   logic [DATA_WIDTH-1:0] rd_data_ff;
   logic                  found_ff;
   logic [STATUS_W-1:0]   status_ff, status_in;

   logic [STATUS_W-1:0]   rsp_status_ff;
   logic                  rsp_found_ff;
   logic [POS_W-1:0]      rsp_match_ff;
   logic [POS_W-1:0]      rsp_length_ff;

   logic [POS_W-1:0]      pos_eff;
   logic                  ins_bad, full, pos_bad;
   logic [ADDR_W-1:0]     rd_addr, put_addr;
   logic [CNT_W-1:0]      idx_up, idx_dn;

   // Positions below one act as one for insert; update never gets that far
   // with a zero position, so the same target address serves both.
   assign pos_eff  = (pos_ff == '0) ? POS_W'(1) : pos_ff;
   assign ins_bad  = ({1'b0, pos_eff} > ((POS_W + 1)'(count_ff) + (POS_W + 1)'(1)));
   assign full     = (count_ff == CNT_W'(CAPACITY));
   assign pos_bad  = (pos_ff == '0) || ((POS_W + 1)'(pos_ff) > (POS_W + 1)'(count_ff));
   assign put_addr = ADDR_W'(pos_eff - POS_W'(1));
   assign idx_up   = idx_ff + CNT_W'(1);
   assign idx_dn   = idx_ff - CNT_W'(1);

   always_comb begin
      status_in = ST_DONE;
      case (op_ff)
         OP_INSERT: begin
            if (ins_bad) begin
               status_in = ST_BADPOS;
            end else if (full) begin
               status_in = ST_FULL;
            end
         end
         OP_DELETE, OP_UPDATE: begin
            if (pos_bad) begin
               status_in = ST_BADPOS;
            end
         end
         default: status_in = ST_DONE;
      endcase
   end

   always_comb begin
      stat.op     = op_ff;
      stat.reject = (status_in != ST_DONE);
      stat.match  = (rd_data_ff == word_ff);
      case (op_ff)
         OP_INSERT: stat.more = ((POS_W + 1)'(idx_ff) >= (POS_W + 1)'(pos_eff));
         OP_DELETE: stat.more = ((CNT_W + 1)'(idx_up) < (CNT_W + 1)'(count_ff));
         default:   stat.more = (idx_ff < count_ff);
      endcase
   end

   // Insert moves entries up by reading below, delete moves them down by
   // reading above, search walks upward.
   always_comb begin
      case (op_ff)
         OP_INSERT: rd_addr = idx_dn[ADDR_W-1:0];
         OP_DELETE: rd_addr = idx_up[ADDR_W-1:0];
         default:   rd_addr = idx_ff[ADDR_W-1:0];
      endcase
   end

   always_comb begin
      idx_in = idx_ff;
      if (cmd.idx_init) begin
         case (op_ff)
            OP_INSERT: idx_in = count_ff;
            OP_DELETE: idx_in = CNT_W'(pos_ff - POS_W'(1));
            default:   idx_in = '0;
         endcase
      end else if (cmd.idx_step) begin
         idx_in = (op_ff == OP_INSERT) ? idx_dn : idx_up;
      end
   end

   always_comb begin
      count_in = count_ff;
      if (cmd.count_inc) begin
         count_in = count_ff + CNT_W'(1);
      end else if (cmd.count_dec) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.mem_rd) begin
         rd_data_ff <= mem[rd_addr];
      end
      if (cmd.shift_wr) begin
         mem[idx_ff[ADDR_W-1:0]] <= rd_data_ff;
      end else if (cmd.put_wr) begin
         mem[put_addr] <= word_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         found_ff <= 1'b0;
      end else begin
         count_ff <= count_in;
         if (cmd.load_req) begin
            found_ff <= 1'b0;
         end else if (cmd.set_found) begin
            found_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      idx_ff <= idx_in;
      if (cmd.load_req) begin
         op_ff   <= req_opcode;
         pos_ff  <= req_position;
         word_ff <= req_value;
      end
      if (cmd.latch_status) begin
         status_ff <= status_in;
      end
      if (cmd.load_rsp) begin
         rsp_status_ff <= status_ff;
         rsp_found_ff  <= found_ff;
         rsp_match_ff  <= (op_ff == OP_SEARCH) ? POS_W'(idx_ff) : '0;
         rsp_length_ff <= POS_W'(count_ff);
      end
   end

   assign rsp_status      = rsp_status_ff;
   assign rsp_found       = rsp_found_ff;
   assign rsp_match_index = rsp_match_ff;
   assign rsp_length      = rsp_length_ff;

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(CAPACITY))
      else $error("entry count above capacity");

   a_count_step: assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && count_ff != $past(count_ff)) |->
         (count_ff == $past(count_ff) + CNT_W'(1) || count_ff == $past(count_ff) - CNT_W'(1)))
      else $error("entry count moved by more than one");

   a_found_search: assert property (@(posedge clock) disable iff (reset)
      found_ff |-> op_ff == OP_SEARCH)
      else $error("match flag set outside a search");

   a_shift_in_range: assert property (@(posedge clock) disable iff (reset)
      cmd.shift_wr |-> idx_ff < CNT_W'(CAPACITY))
      else $error("shift writes past the store");
`endif

endmodule

`default_nettype wire

>>> src/ple_ctrl.sv
`default_nettype none

module ple_ctrl (
   input  wire                 clock,
   input  wire                 reset,
   input  wire                 req_tvalid,
   output logic                req_tready,
   output logic                rsp_tvalid,
   input  wire                 rsp_tready,
   input  wire  ple_pkg::stat_type stat,
   output ple_pkg::cmd_type    cmd
);
   import ple_pkg::*;

   localparam logic [2:0] S_IDLE     = 3'd0;
   localparam logic [2:0] S_CHECK    = 3'd1;
   localparam logic [2:0] S_SHIFT_RD = 3'd2;
   localparam logic [2:0] S_SHIFT_WR = 3'd3;
   localparam logic [2:0] S_PUT      = 3'd4;
   localparam logic [2:0] S_SCAN_RD  = 3'd5;
   localparam logic [2:0] S_SCAN_CMP = 3'd6;
   localparam logic [2:0] S_FINISH   = 3'd7;

   logic [2:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       rsp_free;

   assign rsp_free   = !rsp_valid_ff || rsp_tready;
   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               cmd.load_req = 1'b1;
               state_in     = S_CHECK;
            end
         end
         S_CHECK: begin
            cmd.latch_status = 1'b1;
            cmd.idx_init     = 1'b1;
            if (stat.reject) begin
               state_in = S_FINISH;
            end else begin
               case (stat.op)
                  OP_SEARCH: state_in = S_SCAN_RD;
                  OP_UPDATE: state_in = S_PUT;
                  default:   state_in = S_SHIFT_RD;
               endcase
            end
         end
         S_SHIFT_RD: begin
            if (stat.more) begin
               cmd.mem_rd = 1'b1;
               state_in   = S_SHIFT_WR;
            end else if (stat.op == OP_INSERT) begin
               state_in = S_PUT;
            end else begin
               cmd.count_dec = 1'b1;
               state_in      = S_FINISH;
            end
         end
         S_SHIFT_WR: begin
            cmd.shift_wr = 1'b1;
            cmd.idx_step = 1'b1;
            state_in     = S_SHIFT_RD;
         end
         S_PUT: begin
            cmd.put_wr    = 1'b1;
            cmd.count_inc = (stat.op == OP_INSERT);
            state_in      = S_FINISH;
         end
         S_SCAN_RD: begin
            if (stat.more) begin
               cmd.mem_rd = 1'b1;
               state_in   = S_SCAN_CMP;
            end else begin
               state_in = S_FINISH;
            end
         end
         S_SCAN_CMP: begin
            if (stat.match) begin
               cmd.set_found = 1'b1;
               state_in      = S_FINISH;
            end else begin
               cmd.idx_step = 1'b1;
               state_in     = S_SCAN_RD;
            end
         end
         S_FINISH: begin
            if (rsp_free) begin
               cmd.load_rsp = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.load_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

`ifndef SYNTHESIS
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.load_rsp |-> rsp_free)
      else $error("result register loaded while a result is stalled");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> rsp_tvalid)
      else $error("result beat dropped before it was taken");

   a_load_when_ready: assert property (@(posedge clock) disable iff (reset)
      cmd.load_req |-> req_tready)
      else $error("request loaded while the input was not ready");
`endif

endmodule

`default_nettype wire

>>> src/positional_list_engine_unit.sv
`default_nettype none

// Each operation runs to completion through a walk of the store: a rejected operation and
// update do not walk it; insert and delete walk the entries that move, and search walks
// the entries that it compares, stopping at the first hit.
// Throughput: one operation at a time; the next beat is taken once the result is registered.
// Reset (synchronous, active high) empties the list and drops any pending result; the
// entry store itself is not cleared since only entries below the length are ever read.

module positional_list_engine_unit (
   input  wire         clock,
   input  wire         reset,
   input  wire         req_tvalid,
   output logic        req_tready,
   // Fields from bit 0: opcode[1:0], position[8:2], value[40:9], zero fill[47:41].
   input  wire  [47:0] req_tdata,
   output logic        rsp_tvalid,
   input  wire         rsp_tready,
   // Fields from bit 0: status[1:0], found[2], match_index[9:3], length[16:10],
   // zero fill[23:17].
   output logic [23:0] rsp_tdata
);
   import ple_pkg::*;

   cmd_type               cmd;
   stat_type              stat;
   logic [STATUS_W-1:0]   rsp_status;
   logic                  rsp_found;
   logic [POS_W-1:0]      rsp_match_index;
   logic [POS_W-1:0]      rsp_length;

   // The controller sequences each operation: it checks the request, then walks
   // the store one entry per read and write pair (per read and compare pair for search), then
   // hands the result to the output register, which frees the request side while a result waits.
   ple_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   // The datapath holds the entry memory, the length and the walk index.
   ple_datapath u_datapath (
      .clock           (clock),
      .reset           (reset),
      .req_opcode      (req_tdata[1:0]),
      .req_position    (req_tdata[8:2]),
      .req_value       (req_tdata[40:9]),
      .cmd             (cmd),
      .stat            (stat),
      .rsp_status      (rsp_status),
      .rsp_found       (rsp_found),
      .rsp_match_index (rsp_match_index),
      .rsp_length      (rsp_length)
   );

   assign rsp_tdata = {7'd0, rsp_length, rsp_match_index, rsp_found, rsp_status};

endmodule

`default_nettype wire
